FILE: hw/rtl/msgp_pkg.sv
// ----------------------------------------------------------------------------
// msgp_pkg
// Shared types and constants of the MessagePack stream tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package msgp_pkg;

  // token kinds
  localparam logic [3:0] KIND_NONE    = 4'd0;
  localparam logic [3:0] KIND_INT     = 4'd1;
  localparam logic [3:0] KIND_NIL     = 4'd2;
  localparam logic [3:0] KIND_BOOL    = 4'd3;
  localparam logic [3:0] KIND_F32     = 4'd4;
  localparam logic [3:0] KIND_F64     = 4'd5;
  localparam logic [3:0] KIND_STR     = 4'd6;
  localparam logic [3:0] KIND_BIN     = 4'd7;
  localparam logic [3:0] KIND_PAYLOAD = 4'd8;
  localparam logic [3:0] KIND_ARRAY   = 4'd9;
  localparam logic [3:0] KIND_MAP     = 4'd10;

  // message status
  localparam logic [1:0] STAT_PROGRESS = 2'd0;
  localparam logic [1:0] STAT_DONE     = 2'd1;
  localparam logic [1:0] STAT_ERROR    = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_TAG  = 3'd1;
  localparam logic [2:0] ERR_TOO_DEEP = 3'd2;
  localparam logic [2:0] ERR_TOO_MANY = 3'd3;
  localparam logic [2:0] ERR_KEY_TYPE = 3'd4;
  localparam logic [2:0] ERR_TRUNC    = 3'd5;
  localparam logic [2:0] ERR_TRAILING = 3'd6;

  // map key classes
  localparam logic [1:0] KEY_UNSET = 2'd0;
  localparam logic [1:0] KEY_INT   = 2'd1;
  localparam logic [1:0] KEY_STR   = 2'd2;

  // header tags that need special handling
  localparam logic [7:0] TAG_BIN8   = 8'hc4;
  localparam logic [7:0] TAG_BIN16  = 8'hc5;
  localparam logic [7:0] TAG_BIN32  = 8'hc6;
  localparam logic [7:0] TAG_F32    = 8'hca;
  localparam logic [7:0] TAG_F64    = 8'hcb;
  localparam logic [7:0] TAG_INT8   = 8'hd0;
  localparam logic [7:0] TAG_INT16  = 8'hd1;
  localparam logic [7:0] TAG_INT32  = 8'hd2;
  localparam logic [7:0] TAG_STR8   = 8'hd9;
  localparam logic [7:0] TAG_STR16  = 8'hda;
  localparam logic [7:0] TAG_STR32  = 8'hdb;
  localparam logic [7:0] TAG_ARR16  = 8'hdc;
  localparam logic [7:0] TAG_ARR32  = 8'hdd;
  localparam logic [7:0] TAG_MAP16  = 8'hde;
  localparam logic [7:0] TAG_MAP32  = 8'hdf;

  localparam logic [31:0] DEFAULT_MAX_ELEMS = 32'd1000000;

  // coarse class of a tag byte, worked out in the front part
  typedef enum logic [3:0] {
    TC_POSINT,
    TC_NEGINT,
    TC_FIXMAP,
    TC_FIXARR,
    TC_FIXSTR,
    TC_NIL,
    TC_BOOL,
    TC_HEADER,
    TC_BAD
  } tag_cls_e;

  // one classified input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    tag_cls_e   cls;
    logic [3:0] hdr_len;
    logic [1:0] key_cls;
  } item_t;

  // one open container
  typedef struct packed {
    logic [31:0] remaining;
    logic        is_map;
    logic        in_value;
    logic [1:0]  key_class;
  } lvl_entry_t;

  // one result word
  typedef struct packed {
    logic [3:0]        token_kind;
    logic signed [63:0] token_value;
    logic [8:0]        token_depth;
    logic              is_map_key;
    logic [1:0]        status;
    logic [2:0]        error_code;
  } token_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msgp_if.sv
// ----------------------------------------------------------------------------
// msgp_in_if / msgp_out_if
// Valid/ready channels for encoded bytes and for result tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface msgp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface msgp_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic signed [63:0] token_value;
  logic [8:0]         token_depth;
  logic               is_map_key;
  logic [1:0]         status;
  logic [2:0]         error_code;

  modport source (output valid, output token_kind, output token_value, output token_depth,
                  output is_map_key, output status, output error_code, input ready);
  modport sink   (input valid, input token_kind, input token_value, input token_depth,
                  input is_map_key, input status, input error_code, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/msgp_ram.sv
// ----------------------------------------------------------------------------
// msgp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msgp_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/msgp_front.sv
// ----------------------------------------------------------------------------
// msgp_front
// Accepts encoded bytes, classifies the tag byte and queues the word.
// ----------------------------------------------------------------------------
`default_nettype none

module msgp_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  msgp_in_if.sink        byte_in,
  output msgp_pkg::item_t item_o,
  output logic           item_valid_o,
  input  wire logic      item_pop_i
);
  import msgp_pkg::*;

  item_t      ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  item_t      cls_item;
  logic       push, pop;

  // number of header bytes after a tag
  function automatic logic [3:0] hdr_len(input logic [7:0] b);
    logic [3:0] n;
    case (b)
      8'hc4, 8'hcc, 8'hd0, 8'hd9:                      n = 4'd1;
      8'hc5, 8'hcd, 8'hd1, 8'hda, 8'hdc, 8'hde:        n = 4'd2;
      8'hc6, 8'hca, 8'hce, 8'hd2, 8'hdb, 8'hdd, 8'hdf: n = 4'd4;
      8'hcb, 8'hcf, 8'hd3:                             n = 4'd8;
      default:                                         n = 4'd0;
    endcase
    return n;
  endfunction

  // tag class of a byte when it stands as a tag
  function automatic tag_cls_e classify(input logic [7:0] b);
    tag_cls_e c;
    c = TC_BAD;
    if (b[7] == 1'b0)                 c = TC_POSINT;
    else if (b[7:5] == 3'b111)        c = TC_NEGINT;
    else if (b[7:4] == 4'h8)          c = TC_FIXMAP;
    else if (b[7:4] == 4'h9)          c = TC_FIXARR;
    else if (b[7:5] == 3'b101)        c = TC_FIXSTR;
    else if (b == 8'hc0)              c = TC_NIL;
    else if (b == 8'hc2 || b == 8'hc3) c = TC_BOOL;
    else if (hdr_len(b) != 4'd0)      c = TC_HEADER;
    return c;
  endfunction

  // map key class of a tag
  function automatic logic [1:0] key_cls(input logic [7:0] b);
    logic [1:0] k;
    k = KEY_UNSET;
    if (b[7] == 1'b0 || b[7:5] == 3'b111 || (b >= 8'hcc && b <= 8'hd3)) k = KEY_INT;
    else if (b[7:5] == 3'b101 || (b >= TAG_STR8 && b <= TAG_STR32))     k = KEY_STR;
    return k;
  endfunction

  // classify the incoming word
  always_comb begin
    cls_item.data_byte = byte_in.data_byte;
    cls_item.last_byte = byte_in.last_byte;
    cls_item.cls       = classify(byte_in.data_byte);
    cls_item.hdr_len   = hdr_len(byte_in.data_byte);
    cls_item.key_cls   = key_cls(byte_in.data_byte);
  end

  assign byte_in.ready = (cnt_q != 2'd2);
  assign push          = byte_in.valid && byte_in.ready;
  assign pop           = item_pop_i && (cnt_q != 2'd0);
  assign item_valid_o  = (cnt_q != 2'd0);
  assign item_o        = ent_q[rd_ptr_q];

  // two-entry queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cls_item;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/msgp_back.sv
// ----------------------------------------------------------------------------
// msgp_back
// Executes queued words: header collection, payload counting, container
// stack with cascaded closing, error latching and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msgp_back #(
  parameter int MAX_DEPTH = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire msgp_pkg::item_t  item_i,
  input  wire logic             item_valid_i,
  output logic                  item_pop_o,
  input  wire logic [31:0]      max_elems_i,
  output msgp_pkg::token_t      tok_o,
  output logic                  tok_valid_o,
  input  wire logic             tok_ready_i
);
  import msgp_pkg::*;

  localparam int LW = $clog2(MAX_DEPTH + 2);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_CPL = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [LW-1:0] level_q, level_d;
  lvl_entry_t  top_q, top_d, cur;
  logic        from_ram_q, from_ram_d;
  logic [7:0]  hdr_tag_q, hdr_tag_d;
  logic [3:0]  hdr_left_q, hdr_left_d;
  logic [63:0] acc_q, acc_d, acc_new;
  logic [31:0] pay_q, pay_d;
  logic        root_q, root_d;
  logic [2:0]  err_q, err_d, fin_err;
  logic [3:0]  pkind_q, pkind_d;
  logic [63:0] pval_q, pval_d;
  logic [8:0]  pdepth_q, pdepth_d;
  logic        pkey_q, pkey_d, plast_q, plast_d;
  token_t      tok_q, tok_d;
  logic        ov_q, ov_d;

  logic        out_free, done, cpl_req, has_tok;
  logic        do_open, open_map, do_blob;
  logic [31:0] cnt, blob_len;
  logic [3:0]  blob_kind;
  logic [31:0] lvl_ext;
  logic [LW-1:0] lvl_m1, lvl_m2;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  lvl_entry_t      ram_wdata, ram_rdata;

  // stack of open containers below the cached top entry
  msgp_ram #(.WIDTH($bits(lvl_entry_t)), .DEPTH(MAX_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free    = !ov_q || tok_ready_i;
  assign tok_o       = tok_q;
  assign tok_valid_o = ov_q;
  assign acc_new     = {acc_q[55:0], item_i.data_byte};
  assign lvl_ext     = 32'(level_q);
  assign lvl_m1      = level_q - LW'(1);
  assign lvl_m2      = level_q - LW'(2);

  // execution and sequencing
  always_comb begin
    state_d    = state_q;
    level_d    = level_q;
    top_d      = top_q;
    from_ram_d = 1'b0;
    hdr_tag_d  = hdr_tag_q;
    hdr_left_d = hdr_left_q;
    acc_d      = acc_q;
    pay_d      = pay_q;
    root_d     = root_q;
    err_d      = err_q;
    pkind_d    = pkind_q;
    pval_d     = pval_q;
    pdepth_d   = pdepth_q;
    pkey_d     = pkey_q;
    plast_d    = plast_q;
    tok_d      = tok_q;
    ov_d       = ov_q && !tok_ready_i;
    item_pop_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = lvl_m1[AW-1:0];
    ram_wdata  = top_q;
    ram_raddr  = lvl_m2[AW-1:0];
    cur        = top_q;
    done       = 1'b0;
    cpl_req    = 1'b0;
    do_open    = 1'b0;
    open_map   = 1'b0;
    cnt        = '0;
    do_blob    = 1'b0;
    blob_kind  = KIND_STR;
    blob_len   = '0;
    fin_err    = ERR_NONE;
    has_tok    = 1'b0;

    case (state_q)
      ST_RUN: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          pdepth_d   = lvl_ext[8:0];
          pkey_d     = (level_q != '0) && top_q.is_map && !top_q.in_value;
          pkind_d    = KIND_NONE;
          pval_d     = '0;
          plast_d    = item_i.last_byte;
          if (err_q == ERR_NONE) begin
            if (root_q) begin
              err_d = ERR_TRAILING;
            end else if (pay_q != '0) begin
              // payload byte of a string or binary
              pkind_d = KIND_PAYLOAD;
              pval_d  = {56'd0, item_i.data_byte};
              pay_d   = pay_q - 32'd1;
              cpl_req = (pay_q == 32'd1);
            end else if (hdr_left_q != '0) begin
              // header byte, big endian
              acc_d      = acc_new;
              hdr_left_d = hdr_left_q - 4'd1;
              if (hdr_left_q == 4'd1) begin
                case (hdr_tag_q)
                  TAG_BIN8, TAG_BIN16, TAG_BIN32: begin
                    do_blob = 1'b1; blob_kind = KIND_BIN; blob_len = acc_new[31:0];
                  end
                  TAG_STR8, TAG_STR16, TAG_STR32: begin
                    do_blob = 1'b1; blob_kind = KIND_STR; blob_len = acc_new[31:0];
                  end
                  TAG_F32: begin
                    pkind_d = KIND_F32; pval_d = acc_new; cpl_req = 1'b1;
                  end
                  TAG_F64: begin
                    pkind_d = KIND_F64; pval_d = acc_new; cpl_req = 1'b1;
                  end
                  TAG_INT8: begin
                    pkind_d = KIND_INT; pval_d = {{56{acc_new[7]}}, acc_new[7:0]};
                    cpl_req = 1'b1;
                  end
                  TAG_INT16: begin
                    pkind_d = KIND_INT; pval_d = {{48{acc_new[15]}}, acc_new[15:0]};
                    cpl_req = 1'b1;
                  end
                  TAG_INT32: begin
                    pkind_d = KIND_INT; pval_d = {{32{acc_new[31]}}, acc_new[31:0]};
                    cpl_req = 1'b1;
                  end
                  TAG_ARR16, TAG_ARR32: begin
                    do_open = 1'b1; open_map = 1'b0; cnt = acc_new[31:0];
                  end
                  TAG_MAP16, TAG_MAP32: begin
                    do_open = 1'b1; open_map = 1'b1; cnt = acc_new[31:0];
                  end
                  default: begin
                    pkind_d = KIND_INT; pval_d = acc_new; cpl_req = 1'b1;
                  end
                endcase
              end
            end else if (level_q > LW'(MAX_DEPTH)) begin
              err_d = ERR_TOO_DEEP;
            end else if (pkey_d && (item_i.key_cls == KEY_UNSET ||
                         (top_q.key_class != KEY_UNSET &&
                          top_q.key_class != item_i.key_cls))) begin
              err_d = ERR_KEY_TYPE;
            end else begin
              // tag byte
              if (pkey_d) top_d.key_class = item_i.key_cls;
              case (item_i.cls)
                TC_POSINT: begin
                  pkind_d = KIND_INT; pval_d = {56'd0, item_i.data_byte}; cpl_req = 1'b1;
                end
                TC_NEGINT: begin
                  pkind_d = KIND_INT; pval_d = {{56{1'b1}}, item_i.data_byte};
                  cpl_req = 1'b1;
                end
                TC_FIXMAP: begin
                  do_open = 1'b1; open_map = 1'b1; cnt = {28'd0, item_i.data_byte[3:0]};
                end
                TC_FIXARR: begin
                  do_open = 1'b1; open_map = 1'b0; cnt = {28'd0, item_i.data_byte[3:0]};
                end
                TC_FIXSTR: begin
                  do_blob = 1'b1; blob_kind = KIND_STR;
                  blob_len = {27'd0, item_i.data_byte[4:0]};
                end
                TC_NIL: begin
                  pkind_d = KIND_NIL; pval_d = '0; cpl_req = 1'b1;
                end
                TC_BOOL: begin
                  pkind_d = KIND_BOOL; pval_d = {63'd0, item_i.data_byte[0]}; cpl_req = 1'b1;
                end
                TC_HEADER: begin
                  hdr_tag_d  = item_i.data_byte;
                  hdr_left_d = item_i.hdr_len;
                  acc_d      = '0;
                end
                default: err_d = ERR_BAD_TAG;
              endcase
            end

            // string or binary start
            if (do_blob) begin
              pkind_d = blob_kind;
              pval_d  = {32'd0, blob_len};
              pay_d   = blob_len;
              cpl_req = (blob_len == '0);
            end

            // container start, push the cached top into the stack
            if (do_open) begin
              if (cnt != '0 && cnt > max_elems_i) begin
                err_d = ERR_TOO_MANY;
              end else begin
                pkind_d = open_map ? KIND_MAP : KIND_ARRAY;
                pval_d  = {32'd0, cnt};
                if (cnt == '0) begin
                  cpl_req = 1'b1;
                end else if (level_q <= LW'(MAX_DEPTH)) begin
                  ram_we          = (level_q != '0);
                  ram_wdata       = top_d;
                  top_d.remaining = cnt;
                  top_d.is_map    = open_map;
                  top_d.in_value  = 1'b0;
                  top_d.key_class = KEY_UNSET;
                  level_d         = level_q + LW'(1);
                end
              end
            end
          end
          if (err_d == ERR_NONE && cpl_req) state_d = ST_CPL;
          else                             done    = 1'b1;
        end
      end

      ST_CPL: begin
        // one step of closing values, one level a cycle
        cur = from_ram_q ? ram_rdata : top_q;
        if (level_q == '0) begin
          root_d = 1'b1;
          done   = 1'b1;
        end else if (cur.is_map && !cur.in_value) begin
          top_d          = cur;
          top_d.in_value = 1'b1;
          done           = 1'b1;
        end else begin
          top_d          = cur;
          top_d.in_value = 1'b0;
          if (cur.remaining != '0) top_d.remaining = cur.remaining - 32'd1;
          if (top_d.remaining != '0) begin
            done = 1'b1;
          end else begin
            level_d    = lvl_m1;
            from_ram_d = (level_q >= LW'(2));
          end
        end
      end

      ST_FIN: done = 1'b1;

      default: state_d = ST_RUN;
    endcase

    // load the result register
    if (done) begin
      if (out_free) begin
        fin_err = err_d;
        if (fin_err == ERR_NONE && plast_d && !root_d) fin_err = ERR_TRUNC;
        has_tok = (fin_err == ERR_NONE) && (pkind_d != KIND_NONE);
        tok_d.token_kind  = has_tok ? pkind_d : KIND_NONE;
        tok_d.token_value = has_tok ? pval_d : '0;
        tok_d.token_depth = has_tok ? pdepth_d : '0;
        tok_d.is_map_key  = has_tok ? pkey_d : 1'b0;
        tok_d.status      = (fin_err != ERR_NONE) ? STAT_ERROR :
                            (plast_d ? STAT_DONE : STAT_PROGRESS);
        tok_d.error_code  = fin_err;
        ov_d    = 1'b1;
        err_d   = fin_err;
        state_d = ST_RUN;
        // end of message clears the parse state
        if (plast_d) begin
          level_d    = '0;
          hdr_tag_d  = '0;
          hdr_left_d = '0;
          acc_d      = '0;
          pay_d      = '0;
          root_d     = 1'b0;
          err_d      = ERR_NONE;
        end
      end else begin
        state_d = ST_FIN;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      level_q    <= '0;
      from_ram_q <= 1'b0;
      hdr_tag_q  <= '0;
      hdr_left_q <= '0;
      acc_q      <= '0;
      pay_q      <= '0;
      root_q     <= 1'b0;
      err_q      <= ERR_NONE;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      level_q    <= level_d;
      from_ram_q <= from_ram_d;
      hdr_tag_q  <= hdr_tag_d;
      hdr_left_q <= hdr_left_d;
      acc_q      <= acc_d;
      pay_q      <= pay_d;
      root_q     <= root_d;
      err_q      <= err_d;
      ov_q       <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    pkind_q  <= pkind_d;
    pval_q   <= pval_d;
    pdepth_q <= pdepth_d;
    pkey_q   <= pkey_d;
    plast_q  <= plast_d;
    tok_q    <= tok_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/msgpack_stream_tokenizer_core.sv
// ----------------------------------------------------------------------------
// msgpack_stream_tokenizer_core
// MessagePack byte stream tokenizer with an APB limit register.
// ----------------------------------------------------------------------------
// One result word per input byte. A byte that does not finish a value (header
// byte, container start with items, payload byte before the last) is executed
// in the run state alone; a byte that finishes a value then passes through the
// closing state, which closes the finished containers one by one, each close
// reading the next open container from the stack RAM. A two-entry input queue and a result
// register let both sides stall independently. Register 0 at address 0 holds
// the element limit (write 0 to restore the default of 1000000).
`default_nettype none

module msgpack_stream_tokenizer_core #(
  parameter int MAX_DEPTH = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  msgp_in_if.sink          byte_in,
  msgp_out_if.source       token_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import msgp_pkg::*;

  item_t       item;
  logic        item_valid, item_pop;
  token_t      tok;
  logic [31:0] max_elems_q;

  // element limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_elems_q <= DEFAULT_MAX_ELEMS;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      max_elems_q <= (pwdata == '0) ? DEFAULT_MAX_ELEMS : pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? max_elems_q : '0;

  msgp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_in      (byte_in),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  msgp_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .max_elems_i  (max_elems_q),
    .tok_o        (tok),
    .tok_valid_o  (token_out.valid),
    .tok_ready_i  (token_out.ready)
  );

  // result fields onto the output channel
  assign token_out.token_kind  = tok.token_kind;
  assign token_out.token_value = tok.token_value;
  assign token_out.token_depth = tok.token_depth;
  assign token_out.is_map_key  = tok.is_map_key;
  assign token_out.status      = tok.status;
  assign token_out.error_code  = tok.error_code;

endmodule

`default_nettype wire

FILE: hw/rtl/msgp_checker.sv
// ----------------------------------------------------------------------------
// msgp_checker
// Port-level checks of the tokenizer result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module msgp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  token_kind,
  input wire logic [63:0] token_value,
  input wire logic [1:0]  status,
  input wire logic [2:0]  error_code
);
  import msgp_pkg::*;

  // an error result carries a code and no token
  a_err_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status == STAT_ERROR |-> error_code != ERR_NONE && token_kind == KIND_NONE)
    else $error("error result without code or with token");

  // a clean result carries no code
  a_ok_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status != STAT_ERROR |-> error_code == ERR_NONE)
    else $error("error code on a clean result");

  // no token means a zero value
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && token_kind == KIND_NONE |-> token_value == '0)
    else $error("value on a result without token");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(token_value) && $stable(status))
    else $error("stalled result changed");

endmodule

bind msgpack_stream_tokenizer_core msgp_checker u_msgp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (token_out.valid),
  .out_ready   (token_out.ready),
  .token_kind  (token_out.token_kind),
  .token_value (token_out.token_value),
  .status      (token_out.status),
  .error_code  (token_out.error_code)
);

`default_nettype wire

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MessagePack stream tokenizer: random and
// directed messages go in a byte at a time, and every token word coming out is
// checked against an in-bench tokenizer that tracks the nesting stack, the
// header collector and the element limit register.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msgp_pkg::*;

  localparam int          NEST_LIMIT     = 256;
  localparam logic [2:0]  ADDR_MAX_ELEMS = 3'd0;
  localparam int          WORDS_PER_PASS = 90;
  localparam int          DRAIN_CYCLES   = 20;
  localparam longint      CYCLE_LIMIT    = 1000000;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  logic clk_i;
  logic rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  msgp_in_if  byte_if ();
  msgp_out_if tok_if ();

  msgpack_stream_tokenizer_core #(.MAX_DEPTH(NEST_LIMIT)) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_in  (byte_if),
    .token_out(tok_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  in_word_t   pending_words[$];
  token_t     expected_tokens[$];
  logic [7:0] msg_bytes[$];
  int         mismatches = 0;
  longint     cycles = 0;

  // tokenizer state
  lvl_entry_t  nest_stack[0:NEST_LIMIT];
  int          nest_level;
  logic [7:0]  hdr_tag;
  logic [3:0]  hdr_left;
  logic [63:0] hdr_acc;
  logic [31:0] blob_left;
  logic        root_closed;
  logic [2:0]  err_code;
  logic [31:0] elem_limit;
  logic [3:0]  out_kind;
  logic [63:0] out_value;
  logic        out_key;

  // sender and receiver pacing
  int burst_left = 1;
  int gap_left = 0;
  int hold_cnt = 0;
  bit hold_req = 0;
  int win_left = 0;
  int stall_pct = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void clear_parse();
    for (int i = 0; i <= NEST_LIMIT; i++) nest_stack[i] = '0;
    nest_level  = 0;
    hdr_tag     = '0;
    hdr_left    = '0;
    hdr_acc     = '0;
    blob_left   = '0;
    root_closed = 1'b0;
    err_code    = ERR_NONE;
  endfunction

  function automatic void emit(logic [3:0] kind, logic [63:0] value);
    out_kind  = kind;
    out_value = value;
  endfunction

  // a value finished: advance the enclosing containers, popping full ones
  function automatic void close_value();
    while (1) begin
      if (nest_level == 0 || nest_level > NEST_LIMIT + 1) begin
        root_closed = 1'b1;
        return;
      end
      if (nest_stack[nest_level-1].is_map && !nest_stack[nest_level-1].in_value) begin
        nest_stack[nest_level-1].in_value = 1'b1;
        return;
      end
      nest_stack[nest_level-1].in_value = 1'b0;
      if (nest_stack[nest_level-1].remaining != 0)
        nest_stack[nest_level-1].remaining--;
      if (nest_stack[nest_level-1].remaining != 0) return;
      nest_level--;
    end
  endfunction

  function automatic void open_container(logic is_map, logic [63:0] count);
    if (count != 0 && count > {32'd0, elem_limit}) begin
      err_code = ERR_TOO_MANY;
      return;
    end
    emit(is_map ? KIND_MAP : KIND_ARRAY, count);
    if (count == 0) begin
      close_value();
      return;
    end
    if (nest_level <= NEST_LIMIT) begin
      nest_stack[nest_level].remaining = count[31:0];
      nest_stack[nest_level].is_map    = is_map;
      nest_stack[nest_level].in_value  = 1'b0;
      nest_stack[nest_level].key_class = KEY_UNSET;
      nest_level++;
    end
  endfunction

  function automatic void start_blob(logic [3:0] kind, logic [63:0] len);
    emit(kind, len);
    blob_left = len[31:0];
    if (len == 0) close_value();
  endfunction

  function automatic void finish_header(logic [7:0] t, logic [63:0] v);
    case (t)
      TAG_BIN8, TAG_BIN16, TAG_BIN32: start_blob(KIND_BIN, v);
      TAG_STR8, TAG_STR16, TAG_STR32: start_blob(KIND_STR, v);
      TAG_F32: begin emit(KIND_F32, v); close_value(); end
      TAG_F64: begin emit(KIND_F64, v); close_value(); end
      TAG_INT8: begin emit(KIND_INT, {{56{v[7]}}, v[7:0]}); close_value(); end
      TAG_INT16: begin emit(KIND_INT, {{48{v[15]}}, v[15:0]}); close_value(); end
      TAG_INT32: begin emit(KIND_INT, {{32{v[31]}}, v[31:0]}); close_value(); end
      TAG_ARR16, TAG_ARR32: open_container(1'b0, v);
      TAG_MAP16, TAG_MAP32: open_container(1'b1, v);
      default: begin emit(KIND_INT, v); close_value(); end
    endcase
  endfunction

  function automatic logic [3:0] header_bytes(logic [7:0] b);
    case (b)
      8'hc4, 8'hcc, 8'hd0, 8'hd9: return 4'd1;
      8'hc5, 8'hcd, 8'hd1, 8'hda, 8'hdc, 8'hde: return 4'd2;
      8'hc6, 8'hca, 8'hce, 8'hd2, 8'hdb, 8'hdd, 8'hdf: return 4'd4;
      8'hcb, 8'hcf, 8'hd3: return 4'd8;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [1:0] key_class_of(logic [7:0] b);
    if (b <= 8'h7f || b >= 8'he0 || (b >= 8'hcc && b <= 8'hd3)) return KEY_INT;
    if (b[7:5] == 3'b101 || (b >= TAG_STR8 && b <= TAG_STR32)) return KEY_STR;
    return KEY_UNSET;
  endfunction

  function automatic void tag_byte(logic [7:0] b);
    logic [1:0] cls;
    if (nest_level > NEST_LIMIT) begin
      err_code = ERR_TOO_DEEP;
      return;
    end
    if (out_key) begin
      cls = key_class_of(b);
      if (cls == KEY_UNSET || (nest_stack[nest_level-1].key_class != KEY_UNSET &&
                               nest_stack[nest_level-1].key_class != cls)) begin
        err_code = ERR_KEY_TYPE;
        return;
      end
      nest_stack[nest_level-1].key_class = cls;
    end
    if (b <= 8'h7f) begin emit(KIND_INT, {56'd0, b}); close_value(); end
    else if (b >= 8'he0) begin emit(KIND_INT, {{56{1'b1}}, b}); close_value(); end
    else if (b[7:4] == 4'h8) open_container(1'b1, {60'd0, b[3:0]});
    else if (b[7:4] == 4'h9) open_container(1'b0, {60'd0, b[3:0]});
    else if (b[7:5] == 3'b101) start_blob(KIND_STR, {59'd0, b[4:0]});
    else if (b == 8'hc0) begin emit(KIND_NIL, '0); close_value(); end
    else if (b == 8'hc2 || b == 8'hc3) begin emit(KIND_BOOL, {63'd0, b[0]}); close_value(); end
    else if (header_bytes(b) == 0) err_code = ERR_BAD_TAG;
    else begin
      hdr_tag  = b;
      hdr_left = header_bytes(b);
      hdr_acc  = '0;
    end
  endfunction

  // token word for one accepted byte
  function automatic token_t tokenize_byte(logic [7:0] b, logic last);
    token_t t;
    int     lvl_at_tag;
    lvl_at_tag = nest_level;
    out_kind   = KIND_NONE;
    out_value  = '0;
    out_key    = 1'b0;
    if (nest_level >= 1 && nest_level <= NEST_LIMIT + 1)
      out_key = nest_stack[nest_level-1].is_map && !nest_stack[nest_level-1].in_value;
    if (err_code == ERR_NONE) begin
      if (root_closed) err_code = ERR_TRAILING;
      else if (blob_left > 0) begin
        emit(KIND_PAYLOAD, {56'd0, b});
        blob_left--;
        if (blob_left == 0) close_value();
      end else if (hdr_left > 0) begin
        hdr_acc = {hdr_acc[55:0], b};
        hdr_left--;
        if (hdr_left == 0) finish_header(hdr_tag, hdr_acc);
      end else tag_byte(b);
      if (err_code == ERR_NONE && last && !root_closed) err_code = ERR_TRUNC;
    end
    t.status = (err_code != ERR_NONE) ? STAT_ERROR : (last ? STAT_DONE : STAT_PROGRESS);
    if (t.status == STAT_ERROR || out_kind == KIND_NONE) begin
      out_value  = '0;
      lvl_at_tag = 0;
      out_key    = 1'b0;
    end
    t.token_kind  = (t.status == STAT_ERROR) ? KIND_NONE : out_kind;
    t.token_value = out_value;
    t.token_depth = lvl_at_tag[8:0];
    t.is_map_key  = out_key;
    t.error_code  = err_code;
    if (last) clear_parse();
    return t;
  endfunction

  // byte sender: accept at the rising edge, drive at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      expected_tokens = {expected_tokens,
                         tokenize_byte(byte_if.data_byte, byte_if.last_byte)};
      void'(pending_words.pop_front());
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || gap_left > 0 || pending_words.size() == 0) begin
      if (gap_left > 0 && rst_ni) gap_left--;
      byte_if.valid <= 1'b0;
    end else begin
      byte_if.valid     <= 1'b1;
      byte_if.data_byte <= pending_words[0].data;
      byte_if.last_byte <= pending_words[0].last;
    end
  end

  // token receiver: stall windows of random density plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      tok_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
      tok_if.ready <= 1'b0;
    end else begin
      if (win_left == 0) begin
        win_left = $urandom_range(8, 64);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 20;
          3: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      win_left--;
      tok_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // token checker
  always @(posedge clk_i) begin
    token_t got, want;
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      got = {tok_if.token_kind, tok_if.token_value, tok_if.token_depth,
             tok_if.is_map_key, tok_if.status, tok_if.error_code};
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected token word %p", got);
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("token mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic write_limit(logic [31:0] v);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = ADDR_MAX_ELEMS; pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    elem_limit = (v == 0) ? DEFAULT_MAX_ELEMS : v;
  endtask

  // append one byte to the message being built
  function automatic void put_byte(logic [7:0] b);
    msg_bytes = {msg_bytes, b};
  endfunction

  // queue the collected message bytes, last-marking the final one
  function automatic int send_message();
    in_word_t w;
    int n;
    n = msg_bytes.size();
    for (int i = 0; i < n; i++) begin
      w.data = msg_bytes[i];
      w.last = (i == n - 1);
      pending_words = {pending_words, w};
    end
    msg_bytes.delete();
    return n;
  endfunction

  function automatic void put_be(logic [63:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) put_byte(v[8*i +: 8]);
  endfunction

  function automatic void put_rand(int nbytes);
    for (int i = 0; i < nbytes; i++) put_byte(8'($urandom_range(0, 255)));
  endfunction

  function automatic void add_int();
    case ($urandom_range(0, 7))
      0: put_byte(8'($urandom_range(0, 8'h7f)));
      1: put_byte(8'($urandom_range(8'he0, 8'hff)));
      2: begin put_byte(8'hcc); put_rand(1); end
      3: begin put_byte(8'hcd); put_rand(2); end
      4: begin put_byte($urandom_range(0, 1) ? 8'hce : 8'hd2); put_rand(4); end
      5: begin put_byte($urandom_range(0, 1) ? 8'hcf : 8'hd3); put_rand(8); end
      6: begin put_byte(TAG_INT8); put_rand(1); end
      default: begin put_byte(TAG_INT16); put_rand(2); end
    endcase
  endfunction

  function automatic void add_blob(logic is_str);
    int len;
    len = $urandom_range(0, 5);
    case ($urandom_range(0, 3))
      0: put_byte(is_str ? (8'ha0 | len[7:0]) : TAG_BIN8);
      1: put_byte(is_str ? TAG_STR8 : TAG_BIN8);
      2: put_byte(is_str ? TAG_STR16 : TAG_BIN16);
      default: put_byte(is_str ? TAG_STR32 : TAG_BIN32);
    endcase
    case (msg_bytes[msg_bytes.size()-1])
      TAG_STR8, TAG_BIN8: put_be(64'(len), 1);
      TAG_STR16, TAG_BIN16: put_be(64'(len), 2);
      TAG_STR32, TAG_BIN32: put_be(64'(len), 4);
      default: ;
    endcase
    put_rand(len);
  endfunction

  // random well-formed value; key_cls forces a map key class
  function automatic void add_value(int lvl, logic [1:0] key_cls);
    int n;
    logic [1:0] kc;
    if (key_cls == KEY_INT) begin add_int(); return; end
    if (key_cls == KEY_STR) begin add_blob(1'b1); return; end
    case ($urandom_range(0, (lvl < 4) ? 9 : 6))
      0, 1: add_int();
      2: put_byte($urandom_range(0, 2) == 0 ? 8'hc0 : 8'($urandom_range(8'hc2, 8'hc3)));
      3: begin put_byte(TAG_F32); put_rand(4); end
      4: begin put_byte(TAG_F64); put_rand(8); end
      5: add_blob(1'b1);
      6: add_blob(1'b0);
      7, 8: begin
        n = $urandom_range(0, 4);
        case ($urandom_range(0, 2))
          0: put_byte(8'h90 | n[7:0]);
          1: begin put_byte(TAG_ARR16); put_be(64'(n), 2); end
          default: begin put_byte(TAG_ARR32); put_be(64'(n), 4); end
        endcase
        for (int i = 0; i < n; i++) add_value(lvl + 1, KEY_UNSET);
      end
      default: begin
        n  = $urandom_range(0, 3);
        kc = $urandom_range(0, 1) ? KEY_INT : KEY_STR;
        case ($urandom_range(0, 2))
          0: put_byte(8'h80 | n[7:0]);
          1: begin put_byte(TAG_MAP16); put_be(64'(n), 2); end
          default: begin put_byte(TAG_MAP32); put_be(64'(n), 4); end
        endcase
        for (int i = 0; i < n; i++) begin
          add_value(lvl + 1, kc);
          add_value(lvl + 1, KEY_UNSET);
        end
      end
    endcase
  endfunction

  // well-formed messages, some cut short, padded, corrupted or replaced by noise
  function automatic int add_random_message();
    int pos;
    add_value(0, KEY_UNSET);
    case ($urandom_range(0, 11))
      0: if (msg_bytes.size() > 1) begin
        pos = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > pos) void'(msg_bytes.pop_back());
      end
      1: put_rand(1);
      2: msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      3: begin msg_bytes.delete(); put_rand($urandom_range(1, 6)); end
      default: ;
    endcase
    return send_message();
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic directed_messages();
    int n;
    // integer extremes, nil, bools, an F32 float
    msg_bytes = '{8'h00}; n = send_message();
    msg_bytes = '{8'h7f}; n = send_message();
    msg_bytes = '{8'hff}; n = send_message();
    msg_bytes = '{8'hc0}; n = send_message();
    msg_bytes = '{8'hc2}; n = send_message();
    msg_bytes = '{8'hc3}; n = send_message();
    msg_bytes = '{8'hcf, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    n = send_message();
    msg_bytes = '{8'hd3, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    n = send_message();
    msg_bytes = '{8'hd0, 8'h80}; n = send_message();
    msg_bytes = '{8'hd2, 8'h80, 8'h00, 8'h00, 8'h01}; n = send_message();
    msg_bytes = '{8'hca, 8'h3f, 8'h80, 8'h00, 8'h00}; n = send_message();
    // empty string, array, map
    msg_bytes = '{8'ha0}; n = send_message();
    msg_bytes = '{8'h90}; n = send_message();
    msg_bytes = '{8'h80}; n = send_message();
    // reserved and extension tags
    msg_bytes = '{8'hc1}; n = send_message();
    msg_bytes = '{8'hd4, 8'h01, 8'h02}; n = send_message();
    // map key class mismatch, bad first key
    msg_bytes = '{8'h82, 8'h01, 8'h01, 8'ha1, 8'h61, 8'h02}; n = send_message();
    msg_bytes = '{8'h81, 8'hc0, 8'h00}; n = send_message();
    // trailing byte, truncated header
    msg_bytes = '{8'h01, 8'h02}; n = send_message();
    msg_bytes = '{8'hcd, 8'h01}; n = send_message();
    // count one above the default limit
    msg_bytes = '{8'hdd, 8'h00, 8'h0f, 8'h42, 8'h41}; n = send_message();
    // deepest legal nesting, closed by one value, then one level too deep
    repeat (NEST_LIMIT) put_byte(8'h91);
    put_byte(8'h00);
    n = send_message();
    repeat (NEST_LIMIT + 1) put_byte(8'h91);
    put_byte(8'h00);
    n = send_message();
  endtask

  // stimulus: one pass per limit setting
  initial begin
    logic [31:0] limits[5];
    int sent;
    limits = '{DEFAULT_MAX_ELEMS, 32'd3, 32'd1, 32'hffff_ffff, 32'd0};
    byte_if.valid = 1'b0; byte_if.data_byte = '0; byte_if.last_byte = 1'b0;
    tok_if.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    elem_limit = DEFAULT_MAX_ELEMS;
    clear_parse();
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (int p = 0; p < 5; p++) begin
      if (p != 0) write_limit(limits[p]);
      if (p == 0) directed_messages();
      if (p == 1) hold_req = 1;
      sent = 0;
      while (sent < WORDS_PER_PASS) sent += add_random_message();
      drain();
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
